// ----- rtl/fula_pkg.sv -----
`default_nettype none

package fula_pkg;

    // Fixed field widths of the request / response channels
    localparam int unsigned ADDR_W        = 32;
    localparam int unsigned UNIT_BYTES_W  = 16;
    localparam int unsigned COUNT_W       = 11;
    localparam int unsigned CFG_DATA_W    = 32;
    localparam int unsigned CFG_IDX_W     = 2;
    localparam int unsigned MAX_UNITS_DEF = 1024;

    // Opcodes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    // Response status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_FREE   = 2'd1;
    localparam logic [1:0] STAT_OUT_RANGE = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNITS      = 2'd2;

    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [ADDR_W-1:0] unit_address;
    } fula_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [ADDR_W-1:0]  granted_address;
        logic [COUNT_W-1:0] free_units;
        logic [COUNT_W-1:0] used_units;
        logic               exhausted;
    } fula_rsp_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic finish;
    } fula_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;
    } fula_sts_t;

endpackage

`default_nettype wire

// ----- rtl/fixed_unit_free_list_allocator.sv -----
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_        in   s_valid / s_ready  s_data  : opcode, unit_address
// m_        out  m_valid / m_ready  m_data  : status, granted_address,
//                                              free_units, used_units, exhausted
// cfg_      in   cfg_we             cfg_index, cfg_wdata (no wait, no read-back)
//
// A request goes through accept, execute (stack read and the shared
// unit_bytes multiplier, both registered), then finish into the output register.
// The multiplier and the synchronous free-stack read need the execute step;
// one request is in flight at a time, so none is accepted until the last finishes.
// Reset (aresetn low, synchronous) clears the counts; the free stack is not
// cleared, since only pushed entries are ever popped.
// A stalled m_ channel holds a finished request in the finish step; the output
// register frees up as soon as the held response is taken.

module fixed_unit_free_list_allocator #(
    parameter int unsigned MAX_UNITS = fula_pkg::MAX_UNITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  fula_pkg::cfg_idx_t     cfg_index,
    input  fula_pkg::cfg_data_t    cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  fula_pkg::fula_req_t    s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output fula_pkg::fula_rsp_t    m_data
);
    import fula_pkg::*;

    fula_cmd_t cmd;
    fula_sts_t sts;

    // sequencing: idle -> execute -> finish
    fula_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // config registers, free stack, counts, output register
    fula_dp #(
        .MAX_UNITS (MAX_UNITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // one request at a time: nothing accepted straight after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    // a new response only appears once the controller has left idle
    a_rsp_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("response without a request in flight");

    // failed requests never grant an address
    a_no_grant_on_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != STAT_OK)) |-> (m_data.granted_address == '0))
        else $error("address granted on a failed request");

    // running out of units means the pool reports exhausted
    a_no_free_exhausted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == STAT_NO_FREE)) |-> m_data.exhausted)
        else $error("no free unit reported while pool not exhausted");

endmodule

`default_nettype wire

// ----- rtl/fula_ctrl.sv -----
`default_nettype none

module fula_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  fula_pkg::fula_sts_t     sts,
    output fula_pkg::fula_cmd_t     cmd
);
    import fula_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                // hold until the output register can take the response
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fula_dp.sv -----
`default_nettype none

module fula_dp #(
    parameter int unsigned MAX_UNITS = fula_pkg::MAX_UNITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  fula_pkg::cfg_idx_t      cfg_index,
    input  fula_pkg::cfg_data_t     cfg_wdata,
    input  fula_pkg::fula_req_t     s_data,
    input  fula_pkg::fula_cmd_t     cmd,
    output fula_pkg::fula_sts_t     sts,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output fula_pkg::fula_rsp_t     m_data
);
    import fula_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_UNITS + 1);
    localparam int unsigned FW    = CNT_W + 1;
    localparam int unsigned IDX_W = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int unsigned NW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int unsigned PW    = UNIT_BYTES_W + CNT_W;
    localparam int unsigned CW    = (PW > ADDR_W) ? PW : ADDR_W;

    // configuration
    logic [ADDR_W-1:0]       pool_base_reg;
    logic [UNIT_BYTES_W-1:0] unit_bytes_reg;
    logic [COUNT_W-1:0]      units_reg;

    // allocator state
    logic [CNT_W-1:0] stack_top_reg, stack_top_next;
    logic [CNT_W-1:0] never_issued_reg, never_issued_next;
    logic [ADDR_W-1:0] stack_mem [MAX_UNITS];

    // per-request working registers
    fula_req_t         req_reg;
    logic [PW-1:0]     prod_reg;
    logic [ADDR_W-1:0] offset_reg;
    logic [ADDR_W-1:0] rd_data_reg;

    logic      m_valid_reg;
    fula_rsp_t m_data_reg;

    logic [NW-1:0]     n_wide;
    logic [CNT_W-1:0]  n_units;
    logic [CNT_W-1:0]  mul_b;
    logic [IDX_W-1:0]  rd_idx;
    logic [CNT_W-1:0]  top_dec;
    logic [FW-1:0]     free_now, free_next, used_next;
    logic              push;
    logic [1:0]        status;
    logic [ADDR_W-1:0] granted;

    // pool size, clamped to the stack depth
    always_comb begin
        n_wide  = (NW'(units_reg) > NW'(MAX_UNITS)) ? NW'(MAX_UNITS) : NW'(units_reg);
        n_units = CNT_W'(n_wide);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg  <= '0;
            unit_bytes_reg <= UNIT_BYTES_W'(1);
            units_reg      <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_POOL_BASE:  pool_base_reg  <= cfg_wdata[ADDR_W-1:0];
                CFG_UNIT_BYTES: unit_bytes_reg <= cfg_wdata[UNIT_BYTES_W-1:0];
                CFG_UNITS:      units_reg      <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // one shared multiplier: issue offset for alloc, pool span for release
    assign top_dec = stack_top_reg - CNT_W'(1);
    assign rd_idx  = top_dec[IDX_W-1:0];
    assign mul_b   = (req_reg.opcode == OP_ALLOC) ? (never_issued_reg - CNT_W'(1)) : n_units;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg <= s_data;
        end
        if (cmd.exec) begin
            prod_reg    <= PW'(unit_bytes_reg) * PW'(mul_b);
            offset_reg  <= req_reg.unit_address - pool_base_reg;
            rd_data_reg <= stack_mem[rd_idx];
        end
        if (cmd.finish && push) begin
            stack_mem[stack_top_reg[IDX_W-1:0]] <= req_reg.unit_address;
        end
    end

    assign free_now = FW'(stack_top_reg) + FW'(never_issued_reg);

    always_comb begin
        stack_top_next    = stack_top_reg;
        never_issued_next = never_issued_reg;
        status            = STAT_OK;
        granted           = '0;
        push              = 1'b0;
        case (req_reg.opcode)
            OP_ALLOC: begin
                if (stack_top_reg != '0) begin
                    stack_top_next = top_dec;
                    granted        = rd_data_reg;
                end else if (never_issued_reg != '0) begin
                    never_issued_next = never_issued_reg - CNT_W'(1);
                    granted           = pool_base_reg + ADDR_W'(prod_reg);
                end else begin
                    status = STAT_NO_FREE;
                end
            end
            OP_FREE: begin
                if (CW'(offset_reg) >= CW'(prod_reg)) begin
                    status = STAT_OUT_RANGE;
                end else if (free_now >= FW'(n_units) ||
                             stack_top_reg >= CNT_W'(MAX_UNITS)) begin
                    status = STAT_FULL;
                end else begin
                    push           = 1'b1;
                    stack_top_next = stack_top_reg + CNT_W'(1);
                end
            end
            OP_INIT: begin
                stack_top_next    = '0;
                never_issued_next = n_units;
            end
            default: ;
        endcase
        free_next = FW'(stack_top_next) + FW'(never_issued_next);
        used_next = (free_next >= FW'(n_units)) ? '0 : (FW'(n_units) - free_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_top_reg    <= '0;
            never_issued_reg <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cmd.finish) begin
                stack_top_reg    <= stack_top_next;
                never_issued_reg <= never_issued_next;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_data_reg.status          <= status;
            m_data_reg.granted_address <= granted;
            m_data_reg.free_units      <= COUNT_W'(free_next);
            m_data_reg.used_units      <= COUNT_W'(used_next);
            m_data_reg.exhausted       <= (free_next == '0);
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

endmodule

`default_nettype wire

// ----- tb/pool_ledger_pkg.sv -----
`timescale 1ns / 100ps

package pool_ledger_pkg;

    import fula_pkg::*;

    localparam int unsigned POOL_CAP = MAX_UNITS_DEF;

    class pool_ledger;
        // register copies, reset values
        bit [31:0] base_q;
        bit [15:0] unit_q;
        bit [10:0] units_q;

        // free stack and issue counter
        bit [31:0]   released [POOL_CAP];
        int unsigned top;
        int unsigned fresh;

        fula_rsp_t   pending_rsp [$];
        int unsigned mismatches;

        function new();
            base_q     = '0;
            unit_q     = 16'd1;
            units_q    = '0;
            top        = 0;
            fresh      = 0;
            mismatches = 0;
        endfunction

        // oversized count saturates at the stack depth
        function int unsigned pool_units();
            return (units_q > POOL_CAP) ? POOL_CAP : units_q;
        endfunction

        function void set_reg(cfg_idx_t idx, cfg_data_t data);
            case (idx)
                CFG_POOL_BASE:  base_q  = data;
                CFG_UNIT_BYTES: unit_q  = data[15:0];
                CFG_UNITS:      units_q = data[10:0];
                default: ;
            endcase
        endfunction

        function void record_request(fula_req_t req);
            fula_rsp_t   exp;
            int unsigned n;
            int unsigned free_cnt;
            bit [31:0]   offset;
            bit [63:0]   span;

            n    = pool_units();
            span = 64'(unit_q) * 64'(n);
            exp  = '0;
            exp.status = STAT_OK;

            case (req.opcode)
                OP_ALLOC: begin
                    if (top != 0) begin
                        top--;
                        exp.granted_address = released[top];
                    end else if (fresh != 0) begin
                        fresh--;
                        exp.granted_address = base_q + 32'(fresh) * 32'(unit_q);
                    end else begin
                        exp.status = STAT_NO_FREE;
                    end
                end
                OP_FREE: begin
                    // range check first, wrap-around offset
                    offset = req.unit_address - base_q;
                    if (64'(offset) >= span) begin
                        exp.status = STAT_OUT_RANGE;
                    end else if (top + fresh >= n || top >= POOL_CAP) begin
                        exp.status = STAT_FULL;
                    end else begin
                        released[top] = req.unit_address;
                        top++;
                    end
                end
                OP_INIT: begin
                    top   = 0;
                    fresh = n;
                end
                default: ;
            endcase

            free_cnt          = top + fresh;
            exp.free_units    = free_cnt[10:0];
            exp.used_units    = (free_cnt >= n) ? 11'd0 : 11'(n - free_cnt);
            exp.exhausted     = (free_cnt == 0);
            pending_rsp.insert(pending_rsp.size(), exp);
        endfunction

        function void check_response(fula_rsp_t got);
            fula_rsp_t exp;

            if (pending_rsp.size() == 0) begin
                $display("%0t: response with none outstanding: %p", $time, got);
                mismatches++;
                return;
            end
            exp = pending_rsp.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
                mismatches++;
            end
            if (got.granted_address !== exp.granted_address) begin
                $display("%0t: granted_address exp %h got %h", $time,
                         exp.granted_address, got.granted_address);
                mismatches++;
            end
            if (got.free_units !== exp.free_units) begin
                $display("%0t: free_units exp %0d got %0d", $time,
                         exp.free_units, got.free_units);
                mismatches++;
            end
            if (got.used_units !== exp.used_units) begin
                $display("%0t: used_units exp %0d got %0d", $time,
                         exp.used_units, got.used_units);
                mismatches++;
            end
            if (got.exhausted !== exp.exhausted) begin
                $display("%0t: exhausted exp %0b got %0b", $time,
                         exp.exhausted, got.exhausted);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ----- tb/fixed_unit_free_list_allocator_tb.sv -----
`timescale 1ns / 100ps

module fixed_unit_free_list_allocator_tb;

    import fula_pkg::*;
    import pool_ledger_pkg::*;

    // unnamed opcode: no operation, reports ok
    localparam logic [1:0] OP_NOP = 2'd3;

    // no-acceptance cycles before giving up; well above the long m_ side hold
    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned LONG_HOLD   = 400;

    logic      aclk;
    logic      aresetn;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    fula_req_t s_data;
    logic      m_valid;
    logic      m_ready;
    fula_rsp_t m_data;

    pool_ledger book = new();

    // per-phase knobs shared with the receiving side
    bit tx_gaps;
    bit rx_gaps;
    bit hold_off_req;

    int unsigned quiet = 0;

    fixed_unit_free_list_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog: counts edges with no request or response taken.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic fula_req_t make_req(logic [1:0] op, logic [31:0] addr);
        fula_req_t r;
        r.opcode       = op;
        r.unit_address = addr;
        return r;
    endfunction

    // Random request against the current pool. Releases mostly land on unit
    // boundaries so the store actually fills; the rest probe the edges of
    // the span, misaligned offsets and arbitrary addresses.
    function automatic fula_req_t random_request(int unsigned alloc_pct);
        int unsigned n;
        int unsigned pick;
        logic [31:0] span;
        logic [31:0] addr;

        n    = book.pool_units();
        span = 32'(book.unit_q) * 32'(n);
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct)
            return make_req(OP_ALLOC, $urandom);
        if (pick >= 97)
            return make_req(OP_INIT, $urandom);
        if (pick >= 95)
            return make_req(OP_NOP, $urandom);

        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
                addr = (n != 0) ? book.base_q + $urandom_range(0, n - 1) * book.unit_q
                                : $urandom;
            6:       addr = (span != 0) ? book.base_q + $urandom_range(0, span - 1)
                                        : $urandom;
            7:       addr = book.base_q + span;     // one past the end
            8:       addr = book.base_q - 1;        // just below, wraps
            default: addr = $urandom;
        endcase
        return make_req(OP_FREE, addr);
    endfunction

    // Offer one request; changes at the falling edge, acceptance seen at the
    // rising edge. valid is only dropped when a gap follows.
    task automatic send_request(fula_req_t req);
        int unsigned gap;

        gap = tx_gaps ? $urandom_range(0, 17) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = req;
        do @(posedge aclk); while (!s_ready);
        book.record_request(req);
    endtask

    // Sender stops and waits for every outstanding response, then waits on
    // for the block to drop back to idle.
    task automatic drain_responses();
        @(negedge aclk);
        s_valid = 1'b0;
        while (book.pending_rsp.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(posedge aclk);
        book.set_reg(idx, data);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Reprogram the whole pool while idle. Upper bits of the narrower
    // registers carry junk, which must be ignored.
    task automatic program_pool(logic [31:0] base, logic [15:0] unit, logic [10:0] units);
        cfg_data_t w;

        drain_responses();
        write_reg(CFG_POOL_BASE, base);
        w = $urandom;
        w[15:0] = unit;
        write_reg(CFG_UNIT_BYTES, w);
        w = $urandom;
        w[10:0] = units;
        write_reg(CFG_UNITS, w);
    endtask

    // Receiving side: random back-pressure per response, plus one long
    // hold on request so the block backs up and stalls s_ready.
    initial begin : rx_side
        int unsigned hold;
        bit          long_done;

        m_ready   = 1'b0;
        long_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            hold = rx_gaps ? $urandom_range(0, 17) : 0;
            if (hold_off_req && !long_done) begin
                hold      = LONG_HOLD;
                long_done = 1'b1;
            end
            if (hold != 0) begin
                m_ready = 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            book.check_response(m_data);
        end
    end

    initial begin : stimulus
        logic [31:0] base;
        logic [15:0] unit;
        logic [10:0] units;
        int unsigned alloc_pct;

        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_POOL_BASE;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        tx_gaps      = 1'b0;
        rx_gaps      = 1'b0;
        hold_off_req = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // --- directed ---
        // Straight after reset the pool is empty: nothing to hand out,
        // every release is out of range, and init gives an empty pool.
        send_request(make_req(OP_ALLOC, 32'h0));
        send_request(make_req(OP_FREE,  32'h0));
        send_request(make_req(OP_NOP,   32'hFFFF_FFFF));
        send_request(make_req(OP_INIT,  32'h0));

        // Three 8-byte units straddling the top of the address space.
        program_pool(32'hFFFF_FFF0, 16'd8, 11'd3);
        send_request(make_req(OP_INIT,  32'h0));
        send_request(make_req(OP_ALLOC, 32'h0));          // wraps to 0
        send_request(make_req(OP_ALLOC, 32'h0));
        send_request(make_req(OP_FREE,  32'h0));
        send_request(make_req(OP_FREE,  32'h0));          // double release passes
        send_request(make_req(OP_FREE,  32'hFFFF_FFF0));  // store full
        send_request(make_req(OP_FREE,  32'h0000_0008));  // one past the span
        send_request(make_req(OP_FREE,  32'hFFFF_FFEF));  // just below base
        send_request(make_req(OP_ALLOC, 32'h0));          // LIFO pops
        send_request(make_req(OP_ALLOC, 32'h0));
        send_request(make_req(OP_ALLOC, 32'h0));
        send_request(make_req(OP_ALLOC, 32'h0));          // exhausted
        send_request(make_req(OP_FREE,  32'h0000_0007));  // misaligned, in span

        // Oversized count and widest unit, no init: counts carry over.
        program_pool(32'h0, 16'hFFFF, 11'h7FF);
        send_request(make_req(OP_FREE,  32'h0));
        send_request(make_req(OP_INIT,  32'h0));
        send_request(make_req(OP_ALLOC, 32'h0));          // highest unit

        // Zero-byte units: everything sits at base, nothing releasable.
        program_pool(32'h8000_0000, 16'd0, 11'd1);
        send_request(make_req(OP_INIT,  32'h0));
        send_request(make_req(OP_ALLOC, 32'h0));
        send_request(make_req(OP_FREE,  32'h8000_0000));
        send_request(make_req(OP_ALLOC, 32'h0));

        // --- random phases ---
        // Mostly small pools so exhaustion and a full store come up often;
        // alloc bias varies per phase to push both ways.
        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 3))
                0:       base = 32'h0;
                1:       base = 32'hFFFF_FFFF;
                default: base = $urandom;
            endcase
            case ($urandom_range(0, 7))
                0:       unit = 16'd1;
                1:       unit = 16'hFFFF;
                2:       unit = 16'd0;
                3:       unit = $urandom;
                default: unit = $urandom_range(1, 64);
            endcase
            case ($urandom_range(0, 9))
                0:       units = 11'd0;
                1:       units = 11'd1;
                2:       units = 11'd1024;
                3:       units = 11'h7FF;
                default: units = $urandom_range(2, 12);
            endcase
            program_pool(base, unit, units);

            tx_gaps   = (ph % 3 != 0);
            rx_gaps   = (ph != 0) && ($urandom_range(0, 2) != 0);
            alloc_pct = 30 + 25 * (ph % 3);

            if ($urandom_range(0, 3) != 0)
                send_request(make_req(OP_INIT, $urandom));
            for (int k = 0; k < 165; k++) begin
                if (ph == 4 && k == 40)
                    hold_off_req = 1'b1;
                send_request(random_request(alloc_pct));
            end
        end

        drain_responses();
        repeat (8) @(posedge aclk);
        if (book.mismatches == 0 && book.pending_rsp.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
